FILE: rtl/wrbm_pkg.sv
package wrbm_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ENTRY_COUNT     = 2'd0;
  localparam logic [1:0] REG_LAYOUT_WILDCARD = 2'd1;
  localparam logic [1:0] REG_STAGE_WILDCARD  = 2'd2;
  localparam logic [1:0] REG_NO_MATCH_CODE   = 2'd3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Match scores: stage weight two, layout weight one
  localparam logic [2:0] SCORE_WC_WC = 3'd3;
  localparam logic [2:0] SCORE_WC_EX = 3'd4;
  localparam logic [2:0] SCORE_EX_WC = 3'd5;
  localparam logic [2:0] SCORE_EX_EX = 3'd6;

  typedef struct packed {
    logic              command;
    logic [7:0]        entry_index;
    logic [7:0]        scene;
    logic [15:0]       layout;
    logic [7:0]        stage;
    logic [7:0]        target;
    logic signed [7:0] entry_tier;
    logic [7:0]        fallback_target;
    logic              use_fallback;
    logic signed [7:0] default_tier;
  } item_t;

  typedef struct packed {
    logic signed [7:0] tier;
    logic              from_default;
  } result_t;

  typedef struct packed {
    logic [7:0]        scene;
    logic [15:0]       layout;
    logic [7:0]        stage;
    logic [7:0]        target;
    logic signed [7:0] tier;
  } entry_t;

  // Query broadcast to every cell during a pass
  typedef struct packed {
    logic [7:0]  scene;
    logic [15:0] layout;
    logic [7:0]  stage;
    logic [7:0]  target;
    logic [15:0] layout_wc;
    logic [7:0]  stage_wc;
  } query_t;

  // Running best match handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [2:0]        score;
    logic signed [7:0] tier;
  } token_t;

endpackage

FILE: rtl/wrbm_cell.sv
module wrbm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  wrbm_pkg::entry_t wr_entry,
  input  logic            active,
  input  wrbm_pkg::query_t query,
  input  wrbm_pkg::token_t tok_in,
  output wrbm_pkg::token_t tok_out
);
  import wrbm_pkg::*;

  entry_t     entry;
  logic       hit;
  logic       st_ex, st_wc, ly_ex, ly_wc;
  logic [2:0] score;
  logic       take;

  // Hold this cell's rule
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  // Score the rule against the query
  always_comb begin
    st_ex = entry.stage == query.stage;
    st_wc = entry.stage == query.stage_wc;
    ly_ex = entry.layout == query.layout;
    ly_wc = entry.layout == query.layout_wc;
    hit   = tok_in.valid && active && (query.scene != 8'd0) &&
            (entry.scene == query.scene) && (entry.target == query.target) &&
            (st_ex || st_wc) && (ly_ex || ly_wc);
    if (st_ex) begin
      score = ly_ex ? SCORE_EX_EX : SCORE_EX_WC;
    end else begin
      score = ly_ex ? SCORE_WC_EX : SCORE_WC_WC;
    end
    take = hit && (!tok_in.found || (score > tok_in.score));
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found <= tok_in.found || take;
    tok_out.score <= take ? score : tok_in.score;
    tok_out.tier  <= take ? entry.tier : tok_in.tier;
  end

endmodule

FILE: rtl/wildcard_rule_best_match_unit.sv
// Wildcard rule table with best-match lookup.
// Items enter on start/item while busy is low. A load item (command 0) writes
// one rule into the cell at entry_index without raising busy and gives no
// result; indexes at or beyond TABLE_DEPTH are dropped. A lookup item
// (command 1) raises busy and sends a token down the chain of TABLE_DEPTH
// cells, one cell per cycle; each cell compares its rule and keeps the best.
// A fallback pass with the fallback target follows when enabled and the
// first pass yields the no-match code. The result appears on result with
// done high, and busy falls; no new item is taken while a lookup runs.
// The receiver cannot stall: done is a one-cycle strobe.
// Configuration registers sit on the APB port at 0x0 entry_count,
// 0x4 layout_wildcard, 0x8 stage_wildcard, 0xC no_match_code; write only
// while idle. Reset clears the registers to their defaults and the control
// state; rule contents are undefined until loaded.
module wildcard_rule_best_match_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wrbm_pkg::item_t   item,
  output logic              done,
  output wrbm_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import wrbm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state;
  logic [8:0]        entry_count;
  logic [15:0]       layout_wc;
  logic [7:0]        stage_wc;
  logic signed [7:0] no_match;
  query_t            query;
  logic              second;
  logic              use_fb;
  logic [7:0]        fb_target;
  logic signed [7:0] dflt_tier;
  logic              launch;
  logic              accept, load;
  entry_t            wr_entry;
  token_t            chain [TABLE_DEPTH+1];
  logic signed [7:0] pass_tier;
  logic              pass_none;

  assign accept = start && !busy;
  assign load   = accept && (item.command == CMD_LOAD) &&
                  (32'(item.entry_index) < TABLE_DEPTH);
  assign busy   = state != ST_IDLE;
  assign pready = 1'b1;

  assign wr_entry = '{scene: item.scene, layout: item.layout, stage: item.stage,
                      target: item.target, tier: item.entry_tier};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 9'd0;
      layout_wc   <= 16'hFFFF;
      stage_wc    <= 8'hFF;
      no_match    <= -8'sd128;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ENTRY_COUNT:     entry_count <= pwdata[8:0];
        REG_LAYOUT_WILDCARD: layout_wc   <= pwdata[15:0];
        REG_STAGE_WILDCARD:  stage_wc    <= pwdata[7:0];
        REG_NO_MATCH_CODE:   no_match    <= pwdata[7:0];
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_ENTRY_COUNT:     prdata = {23'd0, entry_count};
      REG_LAYOUT_WILDCARD: prdata = {16'd0, layout_wc};
      REG_STAGE_WILDCARD:  prdata = {24'd0, stage_wc};
      REG_NO_MATCH_CODE:   prdata = {24'd0, no_match};
    endcase
  end

  // Inject a fresh token at the head of the chain
  assign chain[0] = '{valid: launch, found: 1'b0, score: 3'd0, tier: no_match};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    wrbm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (load && (32'(item.entry_index) == i)),
      .wr_entry (wr_entry),
      .active   (32'(entry_count) > i),
      .query    (query),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  assign pass_tier = chain[TABLE_DEPTH].found ? chain[TABLE_DEPTH].tier : no_match;
  assign pass_none = pass_tier == no_match;

  // Sequence the primary and fallback passes
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.command == CMD_LOOKUP)) begin
            state  <= ST_RUN;
            launch <= 1'b1;
          end
        end
        ST_RUN: begin
          if (chain[TABLE_DEPTH].valid) begin
            if (pass_none && use_fb && !second) begin
              launch <= 1'b1;
            end else begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the query and build the result beat
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && (item.command == CMD_LOOKUP)) begin
      query     <= '{scene: item.scene, layout: item.layout, stage: item.stage,
                     target: item.target, layout_wc: layout_wc,
                     stage_wc: stage_wc};
      second    <= 1'b0;
      use_fb    <= item.use_fallback;
      fb_target <= item.fallback_target;
      dflt_tier <= item.default_tier;
    end else if (state == ST_RUN && chain[TABLE_DEPTH].valid && pass_none &&
                 use_fb && !second) begin
      query.target <= fb_target;
      second       <= 1'b1;
    end
    if (state == ST_RUN && chain[TABLE_DEPTH].valid) begin
      result.tier         <= pass_none ? dflt_tier : pass_tier;
      result.from_default <= pass_none;
    end
  end

endmodule

FILE: rtl/wrbm_checker.sv
module wrbm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input wrbm_pkg::item_t   item,
  input logic              done,
  input logic              pready
);
  import wrbm_pkg::*;

  // A lookup beat makes the block busy
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_LOOKUP |=> busy)
    else $error("lookup accepted without busy");

  // A load beat gives no result and leaves the block free
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_LOAD |=> !busy && !done)
    else $error("load produced a result or busy");

  // A result beat ends the lookup
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("result beat while busy or repeated");

  // The port never inserts wait states
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind wildcard_rule_best_match_unit wrbm_checker u_wrbm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done),
  .pready(pready)
);
